FILE: rtl/ftm_pkg.sv
// package with item types, codes and constants of the flow table metering block
package ftm_pkg;

  localparam int unsigned FlowEntriesDef  = 64;
  localparam logic [31:0] IdleTimeoutRst  = 32'd120000;
  localparam logic [15:0] SweepIntervalRst = 16'd1000;
  localparam logic [15:0] EtherIpv4       = 16'h0800;
  localparam logic [7:0]  ProtoTcp        = 8'd6;
  localparam logic [7:0]  ProtoUdp        = 8'd17;
  localparam logic [7:0]  FlagSynAckMask  = 8'h12;
  localparam logic [7:0]  FlagSyn         = 8'h02;
  localparam logic [7:0]  FlagAck         = 8'h10;
  localparam logic [6:0]  MaxReports      = 7'd64;

  typedef enum logic [0:0] {
    CFG_IDLE_TIMEOUT  = 1'b0,
    CFG_SWEEP_INTERVAL = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    END_FIN      = 2'd0,
    END_RST      = 2'd1,
    END_TCP_IDLE = 2'd2,
    END_UDP_IDLE = 2'd3
  } end_kind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPD,
    S_FIN,
    S_SWEEP,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [16:0] cap_len;
    logic [15:0] ether_type;
    logic [3:0]  header_words;
    logic [7:0]  protocol;
    logic [15:0] total_length;
    logic [7:0]  ttl;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [7:0]  flag_byte;
    logic [31:0] timestamp_ms;
  } in_item_t;

  typedef struct packed {
    logic [31:0] orig_ip;
    logic [31:0] responder_ip;
    logic [31:0] port_pair;
    logic [1:0]  end_kind;
    logic [31:0] duration_ms;
    logic [63:0] packet_counts;
    logic [31:0] src_bytes;
    logic [31:0] dst_bytes;
    logic [15:0] ttl_pair;
    logic [63:0] handshake_ms;
    logic        last_report;
  } out_item_t;

  // packet as broadcast to the cells
  typedef struct packed {
    logic [63:0] akey;
    logic [32:0] pkey;
    logic [31:0] sip;
    logic [15:0] sp;
    logic [15:0] dp;
    logic [15:0] tlen;
    logic [7:0]  ttl;
    logic [7:0]  flags;
    logic [31:0] now;
    logic        tcp;
  } flow_pkt_t;

  typedef struct packed {
    logic valid;
    logic idle;
    logic reported;
    logic tcp;
  } cell_stat_t;

  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

FILE: rtl/ftm_cell.sv
// one flow table entry: key compare, counter update and report fields
module ftm_cell
  import ftm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  flow_pkt_t  pkt_i,
  input  logic [31:0] timeout_i,
  input  logic       upd_i,
  input  logic       any_match_i,
  input  logic       clr_i,
  input  logic       match_prev_i,
  input  logic       free_prev_i,
  output logic       match_next_o,
  output logic       free_next_o,
  output logic       mine_o,
  output logic       fin_o,
  output logic       fin_rst_o,
  output cell_stat_t stat_o,
  output out_item_t  rep_o
);

  logic        valid_q;
  logic [63:0] addr_q, addr_d;
  logic [32:0] ports_q, ports_d;
  logic [31:0] init_ip_q, init_ip_d;
  logic [31:0] init_pp_q, init_pp_d;
  logic [31:0] start_q, start_d, last_q;
  logic [31:0] mk_syn_q, mk_syn_d, mk_sa_q, mk_sa_d;
  logic [3:0]  hf_q, hf_d;
  logic [31:0] pk_i_q, pk_i_d, pk_r_q, pk_r_d;
  logic [31:0] by_i_q, by_i_d, by_r_q, by_r_d;
  logic [7:0]  ttl_i_q, ttl_i_d, ttl_r_q, ttl_r_d;
  logic [31:0] hs1_q, hs1_d, hs2_q, hs2_d;

  logic match, free, alloc, is_init;
  logic [7:0] sa;
  logic [3:0] hf_b;

  assign match        = valid_q && addr_q == pkt_i.akey && ports_q == pkt_i.pkey;
  assign free         = !valid_q;
  assign match_next_o = match_prev_i | match;
  assign free_next_o  = free_prev_i | free;
  assign alloc        = free && !free_prev_i && !any_match_i;
  assign mine_o       = (match && !match_prev_i) || alloc;
  assign hf_b         = alloc ? 4'd0 : hf_q;
  assign fin_o        = mine_o && pkt_i.tcp && (pkt_i.flags[0] || pkt_i.flags[2]) && !hf_b[3];
  assign fin_rst_o    = !pkt_i.flags[0];
  assign sa           = pkt_i.flags & FlagSynAckMask;

  always_comb begin
    addr_d    = alloc ? pkt_i.akey : addr_q;
    ports_d   = alloc ? pkt_i.pkey : ports_q;
    init_ip_d = alloc ? pkt_i.sip : init_ip_q;
    init_pp_d = alloc ? {pkt_i.sp, pkt_i.dp} : init_pp_q;
    start_d   = alloc ? pkt_i.now : start_q;
    mk_syn_d  = alloc ? 32'd0 : mk_syn_q;
    mk_sa_d   = alloc ? 32'd0 : mk_sa_q;
    pk_i_d    = alloc ? 32'd0 : pk_i_q;
    pk_r_d    = alloc ? 32'd0 : pk_r_q;
    by_i_d    = alloc ? 32'd0 : by_i_q;
    by_r_d    = alloc ? 32'd0 : by_r_q;
    ttl_i_d   = alloc ? 8'd0 : ttl_i_q;
    ttl_r_d   = alloc ? 8'd0 : ttl_r_q;
    hs1_d     = alloc ? 32'd0 : hs1_q;
    hs2_d     = alloc ? 32'd0 : hs2_q;
    hf_d      = hf_b;
    is_init   = pkt_i.sip == init_ip_d;
    if (is_init) begin
      pk_i_d = sat_add32(pk_i_d, 32'd1);
      by_i_d = sat_add32(by_i_d, {16'd0, pkt_i.tlen});
      if (ttl_i_d == 8'd0) ttl_i_d = pkt_i.ttl;
    end else begin
      pk_r_d = sat_add32(pk_r_d, 32'd1);
      by_r_d = sat_add32(by_r_d, {16'd0, pkt_i.tlen});
      if (ttl_r_d == 8'd0) ttl_r_d = pkt_i.ttl;
    end
    if (pkt_i.tcp) begin
      if (sa == FlagSyn && !hf_b[0]) begin
        mk_syn_d = pkt_i.now;
        hf_d[0]  = 1'b1;
      end else if (sa == FlagSynAckMask && hf_b[0] && !hf_b[1]) begin
        mk_sa_d = pkt_i.now;
        hf_d[1] = 1'b1;
        hs1_d   = pkt_i.now - mk_syn_d;
        hs2_d   = 32'd0;
      end else if (sa == FlagAck && hf_b[1] && !hf_b[2]) begin
        hf_d[2] = 1'b1;
        hs2_d   = pkt_i.now - mk_sa_d;
      end
      if (fin_o) hf_d[3] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (upd_i && alloc) begin
      valid_q <= 1'b1;
    end else if (clr_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_i && mine_o) begin
      addr_q    <= addr_d;
      ports_q   <= ports_d;
      init_ip_q <= init_ip_d;
      init_pp_q <= init_pp_d;
      start_q   <= start_d;
      last_q    <= pkt_i.now;
      mk_syn_q  <= mk_syn_d;
      mk_sa_q   <= mk_sa_d;
      hf_q      <= hf_d;
      pk_i_q    <= pk_i_d;
      pk_r_q    <= pk_r_d;
      by_i_q    <= by_i_d;
      by_r_q    <= by_r_d;
      ttl_i_q   <= ttl_i_d;
      ttl_r_q   <= ttl_r_d;
      hs1_q     <= hs1_d;
      hs2_q     <= hs2_d;
    end
  end

  assign stat_o.valid    = valid_q;
  assign stat_o.idle     = (pkt_i.now - last_q) > timeout_i;
  assign stat_o.reported = hf_q[3];
  assign stat_o.tcp      = ports_q[0];

  assign rep_o.orig_ip       = init_ip_q;
  assign rep_o.responder_ip  = (init_ip_q == addr_q[63:32]) ? addr_q[31:0] : addr_q[63:32];
  assign rep_o.port_pair     = init_pp_q;
  assign rep_o.end_kind      = END_FIN;
  assign rep_o.duration_ms   = last_q - start_q;
  assign rep_o.packet_counts = {pk_i_q, pk_r_q};
  assign rep_o.src_bytes     = by_i_q;
  assign rep_o.dst_bytes     = by_r_q;
  assign rep_o.ttl_pair      = {ttl_i_q, ttl_r_q};
  assign rep_o.handshake_ms  = {hs1_q, hs2_q};
  assign rep_o.last_report   = 1'b0;

endmodule

FILE: rtl/flow_table_metering_top.sv
// flow table metering: packet checks, flow cells, report sequencing
// Usage: header items enter on in_valid_i/in_stall_o; flow reports leave on
// out_valid_o/out_stall_i, the final report of a packet marked by last_report.
// Configuration (idle timeout, sweep interval) is written through cfg_we_i;
// the user must do so only while the block is idle, which the block itself
// does not enforce. An item passes through accept, cell update, fin report
// check, on a sweep a pass over the flow entries, and a closing step that
// hands the last report on; a report stalled by the receiver holds the
// sequence. The next item is taken when the previous one has finished;
// items failing the checks are dropped while idle. Cell lookup is a row of
// FLOW_ENTRIES parallel compare cells; first-match and first-free pass along it.
// Reports pass through a one-entry holding register and an output register;
// while the receiver stalls, the sequencer waits with no state lost.
// Reset clears the entry valid bits, counters and configuration to defaults
// at once; entry contents are written in full on allocation, so no clearing
// pass is needed.
module flow_table_metering_top
  import ftm_pkg::*;
#(
  parameter int unsigned FLOW_ENTRIES = FlowEntriesDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o,
  input  logic      cfg_we_i,
  input  logic      cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned IW = $clog2(FLOW_ENTRIES);

  state_e state_q, state_d;
  logic [31:0] timeout_q;
  logic [15:0] interval_q;
  logic [15:0] vcnt_q, vcnt_d;
  logic [31:0] dropped_q;
  flow_pkt_t   pkt_q;
  logic [IW-1:0] idx_q, swp_q, sel;
  logic        fin_q, fin_kind_q, sweep_q;
  logic [6:0]  n_q;
  out_item_t   pend_q, out_q, rep, last_rep;
  logic        pend_v_q, out_v_q;

  logic [FLOW_ENTRIES:0] mchain, fchain;
  logic [FLOW_ENTRIES-1:0] mine, fin, finr, clr;
  cell_stat_t  stat [FLOW_ENTRIES];
  out_item_t   crep [FLOW_ENTRIES];
  logic        upd, emit, flush, out_free, can_go, in_ok, tcp_in;
  logic [IW-1:0] idx_enc;
  logic [17:0] need_len;
  logic        p_lt;

  assign mchain[0] = 1'b0;
  assign fchain[0] = 1'b0;

  for (genvar k = 0; k < FLOW_ENTRIES; k++) begin : g_cell
    ftm_cell u_cell (
      .clk_i,
      .rst_ni,
      .pkt_i       (pkt_q),
      .timeout_i   (timeout_q),
      .upd_i       (upd),
      .any_match_i (mchain[FLOW_ENTRIES]),
      .clr_i       (clr[k]),
      .match_prev_i(mchain[k]),
      .free_prev_i (fchain[k]),
      .match_next_o(mchain[k+1]),
      .free_next_o (fchain[k+1]),
      .mine_o      (mine[k]),
      .fin_o       (fin[k]),
      .fin_rst_o   (finr[k]),
      .stat_o      (stat[k]),
      .rep_o       (crep[k])
    );
  end

  always_comb begin
    idx_enc = '0;
    for (int k = 0; k < FLOW_ENTRIES; k++) begin
      if (mine[k]) idx_enc = idx_enc | IW'(k);
    end
  end

  // input checks
  assign tcp_in   = in_item_i.protocol == ProtoTcp;
  assign need_len = 18'd14 + {12'd0, in_item_i.header_words, 2'b00} + (tcp_in ? 18'd20 : 18'd8);
  assign in_ok    = in_item_i.cap_len >= 17'd34 && in_item_i.ether_type == EtherIpv4
                 && (tcp_in || in_item_i.protocol == ProtoUdp)
                 && in_item_i.header_words >= 4'd5 && {1'b0, in_item_i.cap_len} >= need_len;
  assign p_lt     = in_item_i.src_ip < in_item_i.dst_ip;

  assign sel      = (state_q == S_SWEEP) ? swp_q : idx_q;
  assign out_free = !out_v_q || !out_stall_i;
  assign can_go   = !pend_v_q || out_free;
  assign in_stall_o = state_q != S_IDLE;

  always_comb begin
    rep = crep[sel];
    rep.end_kind = END_FIN;
    if (state_q == S_SWEEP) begin
      rep.end_kind = stat[sel].tcp ? END_TCP_IDLE : END_UDP_IDLE;
    end else if (fin_kind_q) begin
      rep.end_kind = END_RST;
    end
  end

  always_comb begin
    last_rep = pend_q;
    last_rep.last_report = 1'b1;
  end

  always_comb begin
    state_d = state_q;
    upd     = 1'b0;
    emit    = 1'b0;
    flush   = 1'b0;
    clr     = '0;
    vcnt_d  = vcnt_q + 16'd1;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ok) state_d = S_UPD;
      end
      S_UPD: begin
        upd     = 1'b1;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (!fin_q) begin
          state_d = sweep_q ? S_SWEEP : S_DONE;
        end else if (can_go) begin
          emit    = 1'b1;
          state_d = sweep_q ? S_SWEEP : S_DONE;
        end
      end
      S_SWEEP: begin
        if (stat[swp_q].valid && stat[swp_q].idle) begin
          if (!stat[swp_q].reported && n_q < MaxReports) begin
            if (can_go) begin
              emit       = 1'b1;
              clr[swp_q] = 1'b1;
              if (swp_q == IW'(FLOW_ENTRIES - 1)) state_d = S_DONE;
            end
          end else begin
            clr[swp_q] = 1'b1;
            if (swp_q == IW'(FLOW_ENTRIES - 1)) state_d = S_DONE;
          end
        end else if (swp_q == IW'(FLOW_ENTRIES - 1)) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!pend_v_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          flush   = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      timeout_q  <= IdleTimeoutRst;
      interval_q <= SweepIntervalRst;
      vcnt_q     <= '0;
      dropped_q  <= '0;
      fin_q      <= 1'b0;
      fin_kind_q <= 1'b0;
      sweep_q    <= 1'b0;
      n_q        <= '0;
      idx_q      <= '0;
      swp_q      <= '0;
      pend_v_q   <= 1'b0;
      out_v_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_IDLE_TIMEOUT:   timeout_q  <= cfg_data_i;
          CFG_SWEEP_INTERVAL: interval_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (state_q == S_IDLE) begin
        n_q   <= '0;
        swp_q <= '0;
      end
      if (upd) begin
        idx_q      <= idx_enc;
        fin_q      <= |fin;
        fin_kind_q <= |(fin & finr);
        if (!(|mine) && dropped_q != 32'hFFFF_FFFF) dropped_q <= dropped_q + 32'd1;
        if (vcnt_d >= interval_q) begin
          vcnt_q  <= '0;
          sweep_q <= 1'b1;
        end else begin
          vcnt_q  <= vcnt_d;
          sweep_q <= 1'b0;
        end
      end
      if (state_q == S_SWEEP && state_d == S_SWEEP) begin
        if (!(stat[swp_q].valid && stat[swp_q].idle) || clr[swp_q]) swp_q <= swp_q + IW'(1);
      end
      if (emit) begin
        n_q      <= n_q + 7'd1;
        pend_v_q <= 1'b1;
      end else if (flush) begin
        pend_v_q <= 1'b0;
      end
      if ((emit && pend_v_q) || flush) begin
        out_v_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      pkt_q.akey  <= p_lt ? {in_item_i.src_ip, in_item_i.dst_ip}
                          : {in_item_i.dst_ip, in_item_i.src_ip};
      pkt_q.pkey  <= p_lt ? {in_item_i.src_port, in_item_i.dst_port, tcp_in}
                          : {in_item_i.dst_port, in_item_i.src_port, tcp_in};
      pkt_q.sip   <= in_item_i.src_ip;
      pkt_q.sp    <= in_item_i.src_port;
      pkt_q.dp    <= in_item_i.dst_port;
      pkt_q.tlen  <= in_item_i.total_length;
      pkt_q.ttl   <= in_item_i.ttl;
      pkt_q.flags <= tcp_in ? in_item_i.flag_byte : 8'd0;
      pkt_q.now   <= in_item_i.timestamp_ms;
      pkt_q.tcp   <= tcp_in;
    end
    if (emit) pend_q <= rep;
    if (emit && pend_v_q) begin
      out_q <= pend_q;
    end else if (flush) begin
      out_q <= last_rep;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

endmodule
